// File: design/rgbled_pkg.sv
package rgbled_pkg;

  // Command codes carried in the cmd field of an input item.
  localparam logic [2:0] CMD_GROUP_WRITE = 3'd0;
  localparam logic [2:0] CMD_TICK        = 3'd1;
  localparam logic [2:0] CMD_CONNECT     = 3'd2;
  localparam logic [2:0] CMD_DISCONNECT  = 3'd3;
  localparam logic [2:0] CMD_SAFETY_STOP = 3'd4;

  localparam int unsigned PIX_W = 5;

  localparam logic [15:0] STORE_RESET     = 16'hF005;
  localparam logic [10:0] BLINK_PERIOD    = 11'd1000;
  localparam logic [31:0] TOGGLE_PERIOD   = 32'd1000;
  localparam logic [10:0] BLINK_STEP      = 11'd100;
  localparam logic [3:0]  BLINK_MAX       = 4'd10;
  localparam logic [7:0]  FULL_LEVEL      = 8'hFF;
  localparam logic [5:0]  LED_COUNT_RESET = 6'd8;
  localparam logic [2:0]  QUADS_MAX       = 3'd4;

  // Rounded-up 2^38 / 1000. For any 32-bit time, bits 60:38 of the product
  // of the time and this value are exactly the time divided by 1000.
  localparam logic [31:0] PHASE_RECIP     = 32'h1062_4DD3;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [3:0]  group_index;
    logic [2:0]  quad_count;
    logic [15:0] led_quad_0;
    logic [15:0] led_quad_1;
    logic [15:0] led_quad_2;
    logic [15:0] led_quad_3;
    logic [31:0] time_ms;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_index;
    logic [7:0]       red_level;
    logic [7:0]       green_level;
    logic [7:0]       blue_level;
    logic             last_pixel;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WRITE,
    ST_PHASE,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    FILL_STORE,
    FILL_GREEN,
    FILL_RED,
    FILL_DARK
  } fill_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic wr_step;
    logic phase_step;
    logic emit_step;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic wr_ignore;
    logic custom;
    logic count_zero;
    logic wr_last;
    logic phase_last;
    logic emit_last;
    logic issue_ok;
    logic pipe_busy;
  } dp_sts_t;

endpackage

// File: design/rgbled_ctrl.sv
module rgbled_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [2:0]          in_cmd,
  input  rgbled_pkg::dp_sts_t sts,
  output logic                in_stall,
  output rgbled_pkg::dp_cmd_t cmd
);

  rgbled_pkg::state_t state_r;
  rgbled_pkg::state_t state_nxt;
  logic               accept;

  // The pipeline stage between the store read and the output register
  // must be empty before a new item may change the fill settings.
  assign in_stall = (state_r != rgbled_pkg::ST_IDLE) || sts.pipe_busy;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rgbled_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rgbled_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (in_cmd)
            rgbled_pkg::CMD_GROUP_WRITE: begin
              if (!sts.wr_ignore) begin
                state_nxt = rgbled_pkg::ST_WRITE;
              end
            end
            rgbled_pkg::CMD_TICK: begin
              if (sts.custom) begin
                state_nxt = rgbled_pkg::ST_PHASE;
              end else if (!sts.count_zero) begin
                state_nxt = rgbled_pkg::ST_EMIT;
              end
            end
            rgbled_pkg::CMD_CONNECT,
            rgbled_pkg::CMD_DISCONNECT,
            rgbled_pkg::CMD_SAFETY_STOP: begin
              if (!sts.count_zero) begin
                state_nxt = rgbled_pkg::ST_EMIT;
              end
            end
            default: state_nxt = rgbled_pkg::ST_IDLE;
          endcase
        end
      end
      rgbled_pkg::ST_WRITE: begin
        if (sts.wr_last) begin
          state_nxt = rgbled_pkg::ST_IDLE;
        end
      end
      rgbled_pkg::ST_PHASE: begin
        if (sts.phase_last) begin
          state_nxt = sts.count_zero ? rgbled_pkg::ST_IDLE : rgbled_pkg::ST_EMIT;
        end
      end
      rgbled_pkg::ST_EMIT: begin
        if (sts.issue_ok && sts.emit_last) begin
          state_nxt = rgbled_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rgbled_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      rgbled_pkg::ST_IDLE:  cmd.accept     = accept;
      rgbled_pkg::ST_WRITE: cmd.wr_step    = 1'b1;
      rgbled_pkg::ST_PHASE: cmd.phase_step = 1'b1;
      rgbled_pkg::ST_EMIT:  cmd.emit_step  = sts.issue_ok;
      default:              cmd            = '0;
    endcase
  end

endmodule

// File: design/rgbled_dp.sv
module rgbled_dp #(
  parameter int unsigned MAX_LEDS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [5:0]            cfg_data,
  input  rgbled_pkg::in_item_t  in_data,
  input  rgbled_pkg::dp_cmd_t   cmd,
  output rgbled_pkg::dp_sts_t   sts,
  output logic                  out_valid,
  input  logic                  out_stall,
  output rgbled_pkg::out_item_t out_data
);

  localparam int unsigned IDX_W = $clog2(MAX_LEDS);
  localparam int unsigned CNT_W = $clog2(MAX_LEDS + 1);

  // Configuration and mode state.
  logic [5:0]           led_count_r;
  logic                 custom_r;
  logic                 toggle_r;
  logic [31:0]          last_toggle_r;
  logic                 link_r;
  rgbled_pkg::fill_t    fill_r;
  rgbled_pkg::in_item_t item_r;

  // Sequencing counters.
  logic [1:0]           wr_k_r;
  logic                 phase_cnt_r;
  logic [22:0]          phase_q_r;
  logic [9:0]           phase_r;
  logic [IDX_W-1:0]     pix_r;

  // Store and read pipeline.
  logic [15:0]          led_mem [MAX_LEDS];
  logic [MAX_LEDS-1:0]  vld_r;
  logic [15:0]          rd_word_r;
  logic                 rd_vld_r;
  logic                 s1_valid_r;
  logic [IDX_W-1:0]     s1_idx_r;
  logic                 s1_last_r;
  logic                 out_valid_r;
  rgbled_pkg::out_item_t out_data_r;
  rgbled_pkg::out_item_t out_data_nxt;

  logic [6:0]           n7;
  logic [CNT_W-1:0]     n_w;
  logic [6:0]           in_start7;
  logic [6:0]           st7;
  logic [6:0]           idx7;
  logic [2:0]           quads;
  logic [2:0]           k3;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_idx;
  logic [15:0]          wr_quad;
  logic [15:0]          wr_word;
  logic                 emit_last;
  logic                 out_adv;
  logic                 s1_adv;
  logic [31:0]          toggle_dt;
  logic                 toggle_due;
  logic                 toggle_eff;
  logic [63:0]          phase_prod;
  logic [31:0]          phase_qm;
  logic [9:0]           phase_rem;
  logic [15:0]          col_word;
  logic [3:0]           col_lvl;
  logic [10:0]          on_time;
  logic                 lit;

  assign cfg_ready = 1'b1;

  // Count in use is the configured count limited to the store depth.
  always_comb begin
    n7  = ({1'b0, led_count_r} > 7'(MAX_LEDS)) ? 7'(MAX_LEDS) : {1'b0, led_count_r};
    n_w = CNT_W'(n7);
  end

  assign in_start7 = {1'b0, in_data.group_index, 2'b00};
  assign st7       = {1'b0, item_r.group_index, 2'b00};
  assign k3        = {1'b0, wr_k_r};
  assign idx7      = st7 + 7'(wr_k_r);
  assign quads     = (item_r.quad_count > rgbled_pkg::QUADS_MAX) ?
                     rgbled_pkg::QUADS_MAX : item_r.quad_count;
  assign wr_en     = cmd.wr_step && (k3 < quads) && (idx7 < n7);
  assign wr_idx    = IDX_W'(idx7);

  always_comb begin
    unique case (wr_k_r)
      2'd0:    wr_quad = item_r.led_quad_0;
      2'd1:    wr_quad = item_r.led_quad_1;
      2'd2:    wr_quad = item_r.led_quad_2;
      default: wr_quad = item_r.led_quad_3;
    endcase
    wr_word = {wr_quad[15:4],
               (wr_quad[3:0] > rgbled_pkg::BLINK_MAX) ? rgbled_pkg::BLINK_MAX : wr_quad[3:0]};
  end

  assign emit_last = (CNT_W'({1'b0, pix_r}) + CNT_W'(1)) == n_w;
  assign out_adv   = !out_valid_r || !out_stall;
  assign s1_adv    = !s1_valid_r || out_adv;

  always_comb begin
    sts.wr_ignore  = (n7 == 7'd0) || (in_start7 >= n7);
    sts.custom     = custom_r;
    sts.count_zero = (n7 == 7'd0);
    sts.wr_last    = ((k3 + 3'd1) >= quads) || ((idx7 + 7'd1) >= n7);
    sts.phase_last = phase_cnt_r;
    sts.emit_last  = emit_last;
    sts.issue_ok   = s1_adv;
    sts.pipe_busy  = s1_valid_r;
  end

  // Link-down toggling is decided from the elapsed time at the tick.
  assign toggle_dt  = in_data.time_ms - last_toggle_r;
  assign toggle_due = toggle_dt >= rgbled_pkg::TOGGLE_PERIOD;
  assign toggle_eff = toggle_due ? !toggle_r : toggle_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      led_count_r   <= rgbled_pkg::LED_COUNT_RESET;
      custom_r      <= 1'b0;
      toggle_r      <= 1'b1;
      last_toggle_r <= '0;
      link_r        <= 1'b0;
    end else begin
      if (cfg_valid) begin
        led_count_r <= cfg_data;
      end
      if (cmd.accept) begin
        unique case (in_data.cmd)
          rgbled_pkg::CMD_GROUP_WRITE: begin
            if (!sts.wr_ignore) begin
              custom_r <= 1'b1;
            end
          end
          rgbled_pkg::CMD_TICK: begin
            if (!custom_r && !link_r && toggle_due) begin
              toggle_r      <= !toggle_r;
              last_toggle_r <= in_data.time_ms;
            end
          end
          rgbled_pkg::CMD_CONNECT: begin
            link_r <= 1'b1;
          end
          rgbled_pkg::CMD_DISCONNECT: begin
            link_r        <= 1'b0;
            custom_r      <= 1'b0;
            toggle_r      <= 1'b0;
            last_toggle_r <= in_data.time_ms;
          end
          rgbled_pkg::CMD_SAFETY_STOP: begin
            custom_r <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  // Item capture and the fill that the next refresh will use.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_r <= in_data;
      unique case (in_data.cmd)
        rgbled_pkg::CMD_TICK: begin
          if (custom_r) begin
            fill_r <= rgbled_pkg::FILL_STORE;
          end else if (link_r) begin
            fill_r <= rgbled_pkg::FILL_GREEN;
          end else begin
            fill_r <= toggle_eff ? rgbled_pkg::FILL_RED : rgbled_pkg::FILL_DARK;
          end
        end
        rgbled_pkg::CMD_CONNECT: fill_r <= rgbled_pkg::FILL_GREEN;
        default:                 fill_r <= rgbled_pkg::FILL_DARK;
      endcase
    end
  end

  // Time modulo the blink period in two steps: the quotient by a reciprocal
  // multiply, then the remainder by a multiply and subtract.
  assign phase_prod = {32'd0, item_r.time_ms} * {32'd0, rgbled_pkg::PHASE_RECIP};
  assign phase_qm   = {9'd0, phase_q_r} * 32'(rgbled_pkg::BLINK_PERIOD);
  assign phase_rem  = 10'(item_r.time_ms - phase_qm);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_k_r      <= '0;
      phase_cnt_r <= 1'b0;
      pix_r       <= '0;
    end else if (cmd.accept) begin
      wr_k_r      <= '0;
      phase_cnt_r <= 1'b0;
      pix_r       <= '0;
    end else begin
      if (cmd.wr_step) begin
        wr_k_r <= wr_k_r + 2'd1;
      end
      if (cmd.phase_step) begin
        phase_cnt_r <= !phase_cnt_r;
      end
      if (cmd.emit_step) begin
        pix_r <= pix_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.phase_step) begin
      if (!phase_cnt_r) begin
        phase_q_r <= phase_prod[60:38];
      end else begin
        phase_r <= phase_rem;
      end
    end
  end

  // LED store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      led_mem[wr_idx] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_step) begin
      rd_word_r <= led_mem[pix_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_step) begin
      rd_vld_r <= vld_r[pix_r];
      s1_idx_r <= pix_r;
      s1_last_r <= emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid_r <= cmd.emit_step;
      end
      if (out_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // Pixel colour; a stored nibble times 17 is the nibble repeated.
  always_comb begin
    col_word = rd_vld_r ? rd_word_r : rgbled_pkg::STORE_RESET;
    col_lvl  = col_word[3:0];
    on_time  = 11'(col_lvl) * rgbled_pkg::BLINK_STEP;
    lit      = (col_lvl != 4'd0) &&
               ((col_lvl >= rgbled_pkg::BLINK_MAX) || ({1'b0, phase_r} < on_time));
    out_data_nxt.pixel_index = rgbled_pkg::PIX_W'(s1_idx_r);
    out_data_nxt.last_pixel  = s1_last_r;
    out_data_nxt.red_level   = '0;
    out_data_nxt.green_level = '0;
    out_data_nxt.blue_level  = '0;
    unique case (fill_r)
      rgbled_pkg::FILL_STORE: begin
        if (lit) begin
          out_data_nxt.red_level   = {col_word[15:12], col_word[15:12]};
          out_data_nxt.green_level = {col_word[11:8], col_word[11:8]};
          out_data_nxt.blue_level  = {col_word[7:4], col_word[7:4]};
        end
      end
      rgbled_pkg::FILL_GREEN: out_data_nxt.green_level = rgbled_pkg::FULL_LEVEL;
      rgbled_pkg::FILL_RED:   out_data_nxt.red_level   = rgbled_pkg::FULL_LEVEL;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_adv && s1_valid_r) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: design/rgb_led_blink_controller.sv
// RGB LED string controller. Each input item is one command: a group write
// stores up to four LEDs (4-bit red, green, blue and a blink level clamped to
// ten) starting at LED 4 * group_index and, unless it starts past the end of
// the string, turns custom mode on; a tick, connect, disconnect or safety stop
// produces one colour transfer per LED on the output channel, LED 0 first,
// with last_pixel set on the final one. In custom mode an LED shows its stored
// colour while the time modulo 1000 ms is below level * 100; otherwise the
// string is solid green while connected and blinks red at a one second toggle
// while disconnected. The LED count is set through the configuration channel,
// which is always ready and must only be written while the block is idle.
// A group write is taken in and then stores its quads in turn. A refresh that
// is not in custom mode streams one pixel per cycle while the output is not
// stalled, behind the registered store read. A custom-mode tick first computes
// the blink phase (a reciprocal multiply for the quotient of the time by 1000,
// then a multiply and subtract for the remainder). The stream rate is set by
// the single read port of the LED store. A new item is taken as soon as the
// last pixel has left the read stage, while that pixel may still wait in the
// output register. There is no clearing pass after reset: unwritten LEDs read
// as red at blink level five.
module rgb_led_blink_controller #(
  parameter int unsigned MAX_LEDS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  rgbled_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output rgbled_pkg::out_item_t out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [5:0]            cfg_data
);

  // Command and status between the sequencer and the datapath.
  rgbled_pkg::dp_cmd_t dp_cmd;
  rgbled_pkg::dp_sts_t dp_sts;

  rgbled_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_data.cmd),
    .sts      (dp_sts),
    .in_stall (in_stall),
    .cmd      (dp_cmd)
  );

  rgbled_dp #(
    .MAX_LEDS (MAX_LEDS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (dp_cmd),
    .sts       (dp_sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: dv/rgb_led_blink_controller_tb.sv
`timescale 1ns / 1ps

module rgb_led_blink_controller_tb;

  localparam int unsigned MAX_LEDS = 32;
  // Each stored nibble is stretched to a full 8-bit level by this factor.
  localparam int unsigned NIBBLE_SCALE = 17;
  // Cycles to wait after the last pixel before touching the LED count. A group
  // write produces no pixels, and the wait lets a trailing one finish.
  localparam int SETTLE_CYCLES = 48;
  // Worst case: 32 pixels per item, each behind a long output stall, plus the
  // phase computation and a long input gap, over roughly 150 items.
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_PER_PHASE = 21;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  rgbled_pkg::in_item_t  in_data;
  logic                  out_valid;
  logic                  out_stall;
  rgbled_pkg::out_item_t out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [5:0]            cfg_data;

  rgb_led_blink_controller #(
    .MAX_LEDS(MAX_LEDS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // The board keeps its own copy of the LED store, the mode bits and the LED
  // count. Every accepted command is played against that copy, and the pixels
  // the string should show are queued in order for the output checker.
  class led_refresh_board;
    rgbled_pkg::out_item_t expected_pixels[$];
    bit [15:0]   led_mem[MAX_LEDS];
    bit          custom_on;
    bit          red_phase_on;
    bit          link_is_up;
    bit [31:0]   last_flip_ms;
    bit [5:0]    count_reg;
    int          error_count;

    function new();
      foreach (led_mem[i]) led_mem[i] = rgbled_pkg::STORE_RESET;
      custom_on     = 1'b0;
      red_phase_on  = 1'b1;
      link_is_up    = 1'b0;
      last_flip_ms  = '0;
      count_reg     = rgbled_pkg::LED_COUNT_RESET;
      error_count   = 0;
    endfunction

    // Counts above the store size are clamped to the store size.
    function int unsigned live_count();
      return (count_reg > MAX_LEDS) ? MAX_LEDS : count_reg;
    endfunction

    function void set_led_count(bit [5:0] value);
      count_reg = value;
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction

    function void push_pixel(int unsigned led, bit [7:0] red, bit [7:0] green,
                             bit [7:0] blue);
      rgbled_pkg::out_item_t px;
      px.pixel_index = led[rgbled_pkg::PIX_W-1:0];
      px.red_level   = red;
      px.green_level = green;
      px.blue_level  = blue;
      px.last_pixel  = (led + 1 == live_count());
      expected_pixels.push_back(px);
    endfunction

    function void fill_string(bit [7:0] red, bit [7:0] green, bit [7:0] blue);
      for (int unsigned i = 0; i < live_count(); i++) push_pixel(i, red, green, blue);
    endfunction

    function void note_command(rgbled_pkg::in_item_t item);
      int unsigned n;
      int unsigned start;
      int unsigned quads;
      int unsigned led;
      int unsigned phase_ms;
      int unsigned on_ms;
      int unsigned level;
      bit [15:0]   word;
      bit [15:0]   quad_word[4];
      bit [3:0]    blink;
      bit [31:0]   elapsed;
      bit          lit;
      n = live_count();
      case (item.cmd)
        rgbled_pkg::CMD_GROUP_WRITE: begin
          start = int'(item.group_index) * 4;
          // A group that begins past the end of the string is dropped whole.
          if (n == 0 || start >= n) return;
          quads = (item.quad_count > rgbled_pkg::QUADS_MAX) ? rgbled_pkg::QUADS_MAX
                                                           : item.quad_count;
          quad_word[0] = item.led_quad_0;
          quad_word[1] = item.led_quad_1;
          quad_word[2] = item.led_quad_2;
          quad_word[3] = item.led_quad_3;
          for (int unsigned k = 0; k < quads; k++) begin
            led = start + k;
            if (led >= n) break;
            word  = quad_word[k];
            blink = (word[3:0] > rgbled_pkg::BLINK_MAX) ? rgbled_pkg::BLINK_MAX : word[3:0];
            led_mem[led] = {word[15:4], blink};
          end
          // Custom mode turns on even for a write that carries no quad.
          custom_on = 1'b1;
        end
        rgbled_pkg::CMD_TICK: begin
          if (custom_on) begin
            phase_ms = item.time_ms % rgbled_pkg::BLINK_PERIOD;
            for (int unsigned i = 0; i < n; i++) begin
              level = led_mem[i][3:0];
              on_ms = level * rgbled_pkg::BLINK_STEP;
              lit   = (level > 0) &&
                      ((on_ms >= rgbled_pkg::BLINK_PERIOD) || (phase_ms < on_ms));
              if (lit) begin
                push_pixel(i, 8'(led_mem[i][15:12] * NIBBLE_SCALE),
                           8'(led_mem[i][11:8] * NIBBLE_SCALE),
                           8'(led_mem[i][7:4] * NIBBLE_SCALE));
              end else begin
                push_pixel(i, 8'd0, 8'd0, 8'd0);
              end
            end
          end else if (link_is_up) begin
            fill_string(8'd0, rgbled_pkg::FULL_LEVEL, 8'd0);
          end else begin
            // The elapsed time is taken modulo 2^32 so that a wrap of the
            // millisecond counter still counts as time passing.
            elapsed = item.time_ms - last_flip_ms;
            if (elapsed >= rgbled_pkg::TOGGLE_PERIOD) begin
              red_phase_on = !red_phase_on;
              last_flip_ms = item.time_ms;
            end
            fill_string(red_phase_on ? rgbled_pkg::FULL_LEVEL : 8'd0, 8'd0, 8'd0);
          end
        end
        rgbled_pkg::CMD_CONNECT: begin
          link_is_up = 1'b1;
          fill_string(8'd0, rgbled_pkg::FULL_LEVEL, 8'd0);
        end
        rgbled_pkg::CMD_DISCONNECT: begin
          link_is_up   = 1'b0;
          custom_on    = 1'b0;
          red_phase_on = 1'b0;
          last_flip_ms = item.time_ms;
          fill_string(8'd0, 8'd0, 8'd0);
        end
        rgbled_pkg::CMD_SAFETY_STOP: begin
          custom_on = 1'b0;
          fill_string(8'd0, 8'd0, 8'd0);
        end
        default: return;
      endcase
    endfunction

    task report_mismatch(string what);
      error_count++;
      $display("MISMATCH: %s", what);
    endtask

    task check_pixel(rgbled_pkg::out_item_t got);
      rgbled_pkg::out_item_t want;
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("pixel %0d arrived with nothing expected",
                                  got.pixel_index));
        return;
      end
      want = expected_pixels.pop_front();
      if (got.pixel_index !== want.pixel_index)
        report_mismatch($sformatf("pixel_index got %0d want %0d",
                                  got.pixel_index, want.pixel_index));
      if (got.red_level !== want.red_level)
        report_mismatch($sformatf("pixel %0d red got %0d want %0d",
                                  want.pixel_index, got.red_level, want.red_level));
      if (got.green_level !== want.green_level)
        report_mismatch($sformatf("pixel %0d green got %0d want %0d",
                                  want.pixel_index, got.green_level, want.green_level));
      if (got.blue_level !== want.blue_level)
        report_mismatch($sformatf("pixel %0d blue got %0d want %0d",
                                  want.pixel_index, got.blue_level, want.blue_level));
      if (got.last_pixel !== want.last_pixel)
        report_mismatch($sformatf("pixel %0d last_pixel got %0b want %0b",
                                  want.pixel_index, got.last_pixel, want.last_pixel));
    endtask
  endclass

  led_refresh_board sb;
  int cycle_count = 0;
  int in_quiet_left = 0;
  int out_run_left = 0;
  bit out_run_stall = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run guard: a hung handshake or a missing pixel ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Idle length for either side: mostly none, otherwise a pause, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Output side. A pixel transfer happens at an edge where out_valid is high
  // and our stall is low; the stall pattern then alternates free and stalled
  // runs, with an occasional long free run so back-to-back streaming is seen.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_pixel(out_data);
    if (out_run_left == 0) begin
      if (out_run_stall) begin
        out_run_stall = 1'b0;
        out_run_left  = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 6);
      end else begin
        out_run_left  = idle_len();
        out_run_stall = (out_run_left > 0);
        if (out_run_left == 0) out_run_left = 1;
      end
    end
    out_run_left--;
    out_stall <= out_run_stall;
  end

  function automatic rgbled_pkg::in_item_t build_cmd(logic [2:0] op, logic [3:0] grp,
                                                     logic [2:0] qc, logic [15:0] q0,
                                                     logic [15:0] q1, logic [15:0] q2,
                                                     logic [15:0] q3, logic [31:0] stamp);
    rgbled_pkg::in_item_t item;
    item.cmd         = op;
    item.group_index = grp;
    item.quad_count  = qc;
    item.led_quad_0  = q0;
    item.led_quad_1  = q1;
    item.led_quad_2  = q2;
    item.led_quad_3  = q3;
    item.time_ms     = stamp;
    return item;
  endfunction

  // Sends one command. Valid drops only for a chosen gap and the payload is
  // held until the transfer, which is when the board learns of it.
  task automatic push_cmd(input rgbled_pkg::in_item_t item);
    int gap;
    if (in_quiet_left > 0) begin
      in_quiet_left--;
      gap = 0;
    end else begin
      gap = idle_len();
      if ($urandom_range(0, 19) == 0) in_quiet_left = $urandom_range(10, 30);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    sb.note_command(item);
  endtask

  task automatic push_simple(input logic [2:0] op, input logic [31:0] stamp);
    push_cmd(build_cmd(op, 4'd0, 3'd0, 16'h0, 16'h0, 16'h0, 16'h0, stamp));
  endtask

  // Waits until every expected pixel has been seen, then lets a possible
  // trailing group write finish before the caller goes on.
  task automatic settle_string();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_led_count(input logic [5:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_led_count(value);
  endtask

  initial begin
    rgbled_pkg::in_item_t item;
    int          r;
    int unsigned n;
    bit [31:0]   clock_ms;
    logic [5:0]  phase_counts[6];

    sb = new();
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset count of eight LEDs. First the red blink
    // while disconnected: no flip before a full second, a flip at exactly one
    // second, and a flip at the largest value of the millisecond counter.
    push_simple(rgbled_pkg::CMD_TICK, 32'd0);
    push_simple(rgbled_pkg::CMD_TICK, 32'd999);
    push_simple(rgbled_pkg::CMD_TICK, 32'd1000);
    push_simple(rgbled_pkg::CMD_TICK, 32'hFFFF_FFFF);
    push_simple(rgbled_pkg::CMD_CONNECT, 32'd1200);
    push_simple(rgbled_pkg::CMD_TICK, 32'd1300);
    // A group write with no quad still enters custom mode; the reset store
    // (red at blink level five) is lit just below half a second only.
    push_cmd(build_cmd(rgbled_pkg::CMD_GROUP_WRITE, 4'd0, 3'd0, 16'h0, 16'h0, 16'h0,
                       16'h0, 32'd0));
    push_simple(rgbled_pkg::CMD_TICK, 32'd499);
    push_simple(rgbled_pkg::CMD_TICK, 32'd500);
    // Blink above ten is clamped, blink zero stays dark, ten is always lit.
    push_cmd(build_cmd(rgbled_pkg::CMD_GROUP_WRITE, 4'd0, 3'd4, 16'hFFFF, 16'h0000,
                       16'h123A, 16'h8421, 32'd0));
    // A quad count above four carries four quads.
    push_cmd(build_cmd(rgbled_pkg::CMD_GROUP_WRITE, 4'd1, 3'd7, 16'h5A6B, 16'hC3E2,
                       16'h7F09, 16'hEDCC, 32'd0));
    // Groups that start at or past the end of the string are ignored.
    push_cmd(build_cmd(rgbled_pkg::CMD_GROUP_WRITE, 4'd2, 3'd4, 16'hFFFF, 16'hFFFF,
                       16'hFFFF, 16'hFFFF, 32'd0));
    push_cmd(build_cmd(rgbled_pkg::CMD_GROUP_WRITE, 4'd15, 3'd4, 16'h0000, 16'h0000,
                       16'h0000, 16'h0000, 32'd0));
    push_simple(rgbled_pkg::CMD_TICK, 32'd0);
    push_simple(rgbled_pkg::CMD_TICK, 32'd99);
    push_simple(rgbled_pkg::CMD_TICK, 32'd100);
    push_simple(rgbled_pkg::CMD_TICK, 32'hFFFF_FFFF);
    // Safety stop leaves custom mode, so the next tick is green again.
    push_simple(rgbled_pkg::CMD_SAFETY_STOP, 32'd2000);
    push_simple(rgbled_pkg::CMD_TICK, 32'd2100);
    // Disconnect starts the red blink dark, with its timer at the disconnect time.
    push_simple(rgbled_pkg::CMD_DISCONNECT, 32'd5000);
    push_simple(rgbled_pkg::CMD_TICK, 32'd5999);
    push_simple(rgbled_pkg::CMD_TICK, 32'd6000);
    // The three unused command codes do nothing at all.
    push_simple(3'd5, 32'd6100);
    push_simple(3'd6, 32'd6200);
    push_simple(3'd7, 32'd6300);

    // Random part, split into phases at different LED counts: the full
    // store, a single LED, an empty string, a count past the store size that
    // gets clamped, and two sizes off a multiple of four that cut a group short.
    phase_counts[0] = 6'd32;
    phase_counts[1] = 6'd1;
    phase_counts[2] = 6'd0;
    phase_counts[3] = 6'd63;
    phase_counts[4] = 6'd13;
    phase_counts[5] = 6'd6;
    clock_ms = 32'd7000;
    foreach (phase_counts[p]) begin
      settle_string();
      write_led_count(phase_counts[p]);
      n = sb.live_count();
      for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
        // Time mostly moves forward in steps around the blink period, and
        // sometimes jumps anywhere so every bit of it toggles.
        if ($urandom_range(0, 99) < 85) clock_ms = clock_ms + $urandom_range(0, 1500);
        else clock_ms = $urandom();
        item = build_cmd(rgbled_pkg::CMD_TICK, 4'($urandom_range(0, 15)),
                         3'($urandom_range(0, 7)), 16'($urandom()), 16'($urandom()),
                         16'($urandom()), 16'($urandom()), clock_ms);
        r = $urandom_range(0, 99);
        if (r < 36) begin
          item.cmd = rgbled_pkg::CMD_GROUP_WRITE;
          // Most groups land on the string; the rest probe the drop rule.
          if (n > 0 && $urandom_range(0, 99) < 85)
            item.group_index = 4'($urandom_range(0, (n - 1) / 4));
          if ($urandom_range(0, 99) < 70) item.quad_count = 3'($urandom_range(1, 4));
        end else if (r < 76) begin
          item.cmd = rgbled_pkg::CMD_TICK;
        end else if (r < 83) begin
          item.cmd = rgbled_pkg::CMD_CONNECT;
        end else if (r < 89) begin
          item.cmd = rgbled_pkg::CMD_DISCONNECT;
        end else if (r < 94) begin
          item.cmd = rgbled_pkg::CMD_SAFETY_STOP;
        end else begin
          item.cmd = 3'($urandom_range(5, 7));
        end
        push_cmd(item);
      end
    end

    settle_string();
    if (sb.error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
